@@ hdl/chained_hash_table_crc32c_assert.svh @@
// Assertion macros shared by the checker of the chained hash table.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef CHAINED_HASH_TABLE_CRC32C_ASSERT_SVH
`define CHAINED_HASH_TABLE_CRC32C_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/cht_pkg.sv @@
// Shared types, codes and the CRC-32C byte step for the chained hash table.
// No dependencies.
`timescale 1ns / 1ps

package cht_pkg;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

	// The bucket_index port and the bucket count register are sized for this table.
	localparam int MAX_BUCKETS = 1024;

	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] BCOUNT_RESET = 11'd1024;
	localparam logic [9:0] POS_MAX = 10'd1023;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_CRC,
		OP_DIV,
		OP_HRD,
		OP_ALLOC,
		OP_FULL,
		OP_WSTART,
		OP_NRD,
		OP_ADV,
		OP_FOUND,
		OP_UNLINK,
		OP_FREE,
		OP_NOTFOUND,
		OP_EMIT
	} op_t;

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b00_0000_0001,
		ST_IDLE  = 10'b00_0000_0010,
		ST_CRC   = 10'b00_0000_0100,
		ST_DIV   = 10'b00_0000_1000,
		ST_HRD   = 10'b00_0001_0000,
		ST_DEC   = 10'b00_0010_0000,
		ST_WRD   = 10'b00_0100_0000,
		ST_WCMP  = 10'b00_1000_0000,
		ST_FREE  = 10'b01_0000_0000,
		ST_RES   = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic clear_last;
		logic crc_last;
		logic div_last;
		logic free_avail;
		logic fresh_avail;
		logic cur_nil;
		logic key_match;
		logic out_free;
	} dp_stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'b0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

@@ hdl/cht_ctrl.sv @@
// Controller state machine of the chained hash table.
// Depends on cht_pkg; drives the datapath through one operation code per cycle.
`timescale 1ns / 1ps

module cht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cht_pkg::dp_stat_t stat,
	output cht_pkg::dp_cmd_t  cmd
);

	cht_pkg::state_t state_q;
	cht_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd.op = cht_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			cht_pkg::ST_CLEAR: begin
				cmd.op = cht_pkg::OP_CLEAR;
				if (stat.clear_last) state_nxt = cht_pkg::ST_IDLE;
			end
			cht_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = cht_pkg::OP_LOAD;
					state_nxt = cht_pkg::ST_CRC;
				end
			end
			cht_pkg::ST_CRC: begin
				cmd.op = cht_pkg::OP_CRC;
				if (stat.crc_last) state_nxt = cht_pkg::ST_DIV;
			end
			cht_pkg::ST_DIV: begin
				cmd.op = cht_pkg::OP_DIV;
				if (stat.div_last) state_nxt = cht_pkg::ST_HRD;
			end
			cht_pkg::ST_HRD: begin
				cmd.op = cht_pkg::OP_HRD;
				state_nxt = cht_pkg::ST_DEC;
			end
			cht_pkg::ST_DEC: begin
				if (stat.command == cht_pkg::CMD_INSERT) begin
					cmd.op = (stat.free_avail || stat.fresh_avail) ?
						cht_pkg::OP_ALLOC : cht_pkg::OP_FULL;
					state_nxt = cht_pkg::ST_RES;
				end else if (stat.command == cht_pkg::CMD_SEARCH ||
						stat.command == cht_pkg::CMD_DELETE) begin
					cmd.op = cht_pkg::OP_WSTART;
					state_nxt = cht_pkg::ST_WRD;
				end else begin
					cmd.op = cht_pkg::OP_NOTFOUND;
					state_nxt = cht_pkg::ST_RES;
				end
			end
			cht_pkg::ST_WRD: begin
				if (stat.cur_nil) begin
					cmd.op = cht_pkg::OP_NOTFOUND;
					state_nxt = cht_pkg::ST_RES;
				end else begin
					cmd.op = cht_pkg::OP_NRD;
					state_nxt = cht_pkg::ST_WCMP;
				end
			end
			cht_pkg::ST_WCMP: begin
				if (!stat.key_match) begin
					cmd.op = cht_pkg::OP_ADV;
					state_nxt = cht_pkg::ST_WRD;
				end else if (stat.command == cht_pkg::CMD_SEARCH) begin
					cmd.op = cht_pkg::OP_FOUND;
					state_nxt = cht_pkg::ST_RES;
				end else begin
					cmd.op = cht_pkg::OP_UNLINK;
					state_nxt = cht_pkg::ST_FREE;
				end
			end
			cht_pkg::ST_FREE: begin
				cmd.op = cht_pkg::OP_FREE;
				state_nxt = cht_pkg::ST_RES;
			end
			cht_pkg::ST_RES: begin
				if (stat.out_free) begin
					cmd.op = cht_pkg::OP_EMIT;
					state_nxt = cht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = cht_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hdl/cht_dp.sv @@
// Datapath of the chained hash table: CRC, bucket modulo, chain memories, result register.
// Depends on cht_pkg; sequenced by cht_ctrl.
`timescale 1ns / 1ps

module cht_dp #(
	parameter int NODE_POOL = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [10:0]      bucket_count,
	input  logic [1:0]       command,
	input  logic [63:0]      key_word0,
	input  logic [63:0]      key_word1,
	input  logic [63:0]      key_word2,
	input  logic [63:0]      key_word3,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [9:0]       chain_position,
	output logic [9:0]       bucket_index,
	input  cht_pkg::dp_cmd_t cmd,
	output cht_pkg::dp_stat_t stat
);

	localparam int MAX_BUCKETS = cht_pkg::MAX_BUCKETS;
	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int NW = $clog2(NODE_POOL + 1);
	localparam int NAW = $clog2(NODE_POOL);
	localparam logic [NW-1:0] NIL = NW'(NODE_POOL);
	localparam logic [BW-1:0] CLR_LAST = BW'(MAX_BUCKETS - 1);

	logic [cht_pkg::CFG_W-1:0] bcount_q;
	logic [cht_pkg::CFG_W-1:0] eff;
	logic [1:0]   command_q;
	logic [63:0]  key_q [4];
	logic [31:0]  crc_q;
	logic [31:0]  crc_nxt;
	logic [31:0]  dvd_q;
	logic [10:0]  rem_q;
	logic [11:0]  rem_sh;
	logic [4:0]   cnt_q;
	logic [BW-1:0] clr_q;
	logic [BW-1:0] bucket;
	logic [NW-1:0] free_q;
	logic [NW-1:0] fresh_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] prev_q;
	logic [NW-1:0] alloc_node;
	logic [9:0]   pos_q;
	logic [1:0]   res_q;
	logic         out_valid_q;
	logic [1:0]   status_q;
	logic [9:0]   pos_out_q;
	logic [9:0]   bucket_out_q;

	logic [NW-1:0]  heads_mem [MAX_BUCKETS];
	logic [NW-1:0]  links_mem [NODE_POOL];
	logic [255:0]   keys_mem [NODE_POOL];
	logic [NW-1:0]  head_rd_q;
	logic [NW-1:0]  link_rd_q;
	logic [255:0]   key_rd_q;

	logic           heads_we;
	logic [BW-1:0]  heads_wa;
	logic [NW-1:0]  heads_wd;
	logic           links_we;
	logic [NAW-1:0] links_wa;
	logic [NW-1:0]  links_wd;
	logic [NAW-1:0] links_ra;
	logic           keys_we;
	logic           prev_nil;

	// A register value of zero acts as one bucket; a value above the table acts as its size.
	assign eff = (bcount_q == '0) ? 11'd1 :
		(32'(bcount_q) > 32'(MAX_BUCKETS)) ? 11'(MAX_BUCKETS) : bcount_q;
	assign crc_nxt = cht_pkg::crc_byte(crc_q, key_q[cnt_q[4:3]][{cnt_q[2:0], 3'b000} +: 8]);
	assign rem_sh = {rem_q, dvd_q[31]};
	assign bucket = BW'(rem_q);
	assign alloc_node = (free_q != NIL) ? free_q : fresh_q;
	assign prev_nil = (prev_q == NIL);

	assign stat.command = command_q;
	assign stat.clear_last = (clr_q == CLR_LAST);
	assign stat.crc_last = (cnt_q == 5'd31);
	assign stat.div_last = (cnt_q == 5'd31);
	assign stat.free_avail = (free_q != NIL);
	assign stat.fresh_avail = (fresh_q != NIL);
	assign stat.cur_nil = (cur_q == NIL);
	assign stat.key_match = (key_rd_q == {key_q[3], key_q[2], key_q[1], key_q[0]});
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		heads_we = 1'b0;
		heads_wa = bucket;
		heads_wd = link_rd_q;
		links_we = 1'b0;
		links_wa = NAW'(cur_q);
		links_wd = free_q;
		keys_we = 1'b0;
		case (cmd.op)
			cht_pkg::OP_CLEAR: begin
				heads_we = 1'b1;
				heads_wa = clr_q;
				heads_wd = NIL;
			end
			cht_pkg::OP_ALLOC: begin
				heads_we = 1'b1;
				heads_wd = alloc_node;
				links_we = 1'b1;
				links_wa = NAW'(alloc_node);
				links_wd = head_rd_q;
				keys_we = 1'b1;
			end
			cht_pkg::OP_UNLINK: begin
				heads_we = prev_nil;
				links_we = !prev_nil;
				links_wa = NAW'(prev_q);
				links_wd = link_rd_q;
			end
			cht_pkg::OP_FREE: begin
				links_we = 1'b1;
			end
			default: begin
				heads_we = 1'b0;
			end
		endcase
	end

	assign links_ra = (cmd.op == cht_pkg::OP_HRD) ? NAW'(free_q) : NAW'(cur_q);

	always_ff @(posedge clk) begin
		if (heads_we) heads_mem[heads_wa] <= heads_wd;
		head_rd_q <= heads_mem[bucket];
	end

	always_ff @(posedge clk) begin
		if (links_we) links_mem[links_wa] <= links_wd;
		link_rd_q <= links_mem[links_ra];
	end

	always_ff @(posedge clk) begin
		if (keys_we) keys_mem[NAW'(alloc_node)] <= {key_q[3], key_q[2], key_q[1], key_q[0]};
		key_rd_q <= keys_mem[NAW'(cur_q)];
	end

	// Payload registers of the working item.
	always_ff @(posedge clk) begin
		case (cmd.op)
			cht_pkg::OP_LOAD: begin
				command_q <= command;
				key_q[0] <= key_word0;
				key_q[1] <= key_word1;
				key_q[2] <= key_word2;
				key_q[3] <= key_word3;
				crc_q <= cht_pkg::CRC_INIT;
				res_q <= cht_pkg::STATUS_NOT_FOUND;
				pos_q <= '0;
			end
			cht_pkg::OP_CRC: begin
				crc_q <= crc_nxt;
				if (cnt_q == 5'd31) begin
					dvd_q <= ~crc_nxt;
					rem_q <= '0;
				end
			end
			cht_pkg::OP_DIV: begin
				// One restoring step per cycle, dividend taken from the top bit.
				dvd_q <= {dvd_q[30:0], 1'b0};
				if (rem_sh >= {1'b0, eff}) begin
					rem_q <= 11'(rem_sh - {1'b0, eff});
				end else begin
					rem_q <= rem_sh[10:0];
				end
			end
			cht_pkg::OP_ALLOC: res_q <= cht_pkg::STATUS_OK;
			cht_pkg::OP_FULL: res_q <= cht_pkg::STATUS_FULL;
			cht_pkg::OP_WSTART: begin
				cur_q <= head_rd_q;
				prev_q <= NIL;
			end
			cht_pkg::OP_ADV: begin
				prev_q <= cur_q;
				cur_q <= link_rd_q;
				if (pos_q != cht_pkg::POS_MAX) pos_q <= pos_q + 10'd1;
			end
			cht_pkg::OP_FOUND: res_q <= cht_pkg::STATUS_OK;
			cht_pkg::OP_FREE: begin
				res_q <= cht_pkg::STATUS_OK;
				pos_q <= '0;
			end
			cht_pkg::OP_NOTFOUND: begin
				res_q <= cht_pkg::STATUS_NOT_FOUND;
				pos_q <= '0;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == cht_pkg::OP_EMIT) begin
			status_q <= res_q;
			pos_out_q <= pos_q;
			bucket_out_q <= 10'(rem_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= cht_pkg::BCOUNT_RESET;
			cnt_q <= '0;
			clr_q <= '0;
			free_q <= NIL;
			fresh_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) bcount_q <= bucket_count;
			if (cmd.op == cht_pkg::OP_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd.op == cht_pkg::OP_LOAD) begin
				cnt_q <= '0;
			end else if (cmd.op == cht_pkg::OP_CRC || cmd.op == cht_pkg::OP_DIV) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (cmd.op == cht_pkg::OP_ALLOC) begin
				if (free_q != NIL) begin
					free_q <= link_rd_q;
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
			if (cmd.op == cht_pkg::OP_FREE) free_q <= cur_q;
			if (cmd.op == cht_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign chain_position = pos_out_q;
	assign bucket_index = bucket_out_q;

endmodule

@@ hdl/chained_hash_table_crc32c.sv @@
// Top level of the chained hash table with CRC-32C bucket selection.
// Depends on cht_pkg, cht_ctrl and cht_dp.
//
// Channel   Signals                                   Direction
// in        in_valid/in_ready, command, key_word0..3  request in
// out       out_valid/out_ready, status,              result out
//           chain_position, bucket_index
// cfg       cfg_valid/cfg_ready, bucket_count         register write in
//
// After reset the 1024 bucket heads are cleared one per cycle, with in_ready low.
// A request takes an accept step, a CRC step for each key byte, a modulo step for each
// dividend bit, a head read, a decode and a result step.
// Search and delete add a node read and a compare step per chain node compared, and one
// more step when the walk reaches the end of the chain or a delete frees its node.
// The result step waits while an earlier result is held by out_ready. cfg_ready is always high.
`timescale 1ns / 1ps

module chained_hash_table_crc32c #(
	parameter int NODE_POOL = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] bucket_count,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [9:0]  chain_position,
	output logic [9:0]  bucket_index
);

	cht_pkg::dp_cmd_t  cmd;
	cht_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cht_dp #(
		.NODE_POOL   (NODE_POOL)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.bucket_count   (bucket_count),
		.command        (command),
		.key_word0      (key_word0),
		.key_word1      (key_word1),
		.key_word2      (key_word2),
		.key_word3      (key_word3),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.chain_position (chain_position),
		.bucket_index   (bucket_index),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

@@ hdl/cht_checker.sv @@
// Port-level checks of the chained hash table, bound to the top level.
// Depends on cht_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "chained_hash_table_crc32c_assert.svh"

module cht_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [9:0] chain_position
);

	logic status_legal;

	assign status_legal = (status == cht_pkg::STATUS_OK) ||
		(status == cht_pkg::STATUS_NOT_FOUND) || (status == cht_pkg::STATUS_FULL);

	// A held result must not vanish before it is taken.
	`CHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// Status is never the unused code.
	`CHT_ASSERT_SAME(a_status_code, out_valid, status_legal, "bad status code")

	// Only a successful search reports a chain position.
	`CHT_ASSERT_SAME(a_pos_zero, out_valid && status != cht_pkg::STATUS_OK, chain_position == 10'd0, "position on failure")

	// A request is worked alone, so the block is busy right after taking one.
	`CHT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind chained_hash_table_crc32c cht_port_checker u_port_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.chain_position (chain_position)
);
